/* hdl/sspg_pkg.sv */
package sspg_pkg;

  // Counter widths
  localparam int STEP_COUNT_BITS = 32;
  localparam int TIME_BITS       = 16;

  // Field widths of the ports
  localparam int OP_BITS    = 3;
  localparam int COUNT_BITS = 32;
  localparam int CFG_BITS   = 16;
  localparam int INDEX_BITS = 2;

  // Saturation limits
  localparam logic [STEP_COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [TIME_BITS-1:0]       TIME_MAX  = '1;

  // Continuous test run settings, saturated to the counter widths
  localparam longint TEST_STEPS = 5555;
  localparam longint TEST_HIGH  = 100;
  localparam longint TEST_LOW   = 800;
  localparam longint COUNT_LIMIT = (longint'(1) << STEP_COUNT_BITS) - 1;
  localparam longint TIME_LIMIT  = (longint'(1) << TIME_BITS) - 1;
  localparam logic [STEP_COUNT_BITS-1:0] TEST_STEPS_SAT =
    STEP_COUNT_BITS'((TEST_STEPS > COUNT_LIMIT) ? COUNT_LIMIT : TEST_STEPS);
  localparam logic [TIME_BITS-1:0] TEST_HIGH_SAT =
    TIME_BITS'((TEST_HIGH > TIME_LIMIT) ? TIME_LIMIT : TEST_HIGH);
  localparam logic [TIME_BITS-1:0] TEST_LOW_SAT =
    TIME_BITS'((TEST_LOW > TIME_LIMIT) ? TIME_LIMIT : TEST_LOW);

  // Configuration reset values
  localparam logic [CFG_BITS-1:0] PULSE_TICKS_RESET = 16'd100;
  localparam logic [CFG_BITS-1:0] GAP_TICKS_RESET   = 16'd800;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_TICK       = 3'd0;
  localparam logic [OP_BITS-1:0] OP_START      = 3'd1;
  localparam logic [OP_BITS-1:0] OP_STOP       = 3'd2;
  localparam logic [OP_BITS-1:0] OP_START_TEST = 3'd3;
  localparam logic [OP_BITS-1:0] OP_SET_DIR    = 3'd4;

  // Configuration register indexes
  localparam logic [INDEX_BITS-1:0] REG_PULSE_TICKS = 2'd0;
  localparam logic [INDEX_BITS-1:0] REG_GAP_TICKS   = 2'd1;

  // Generator state
  typedef struct packed {
    logic                       running;
    logic                       pulse_high;
    logic [STEP_COUNT_BITS-1:0] steps_left;
    logic [TIME_BITS-1:0]       wait_left;
    logic [TIME_BITS-1:0]       active_high_ticks;
    logic [TIME_BITS-1:0]       active_low_ticks;
    logic                       dir_reg;
    logic                       test_mode;
    logic                       enable_reg;
  } gen_state_t;

  // Per-word result flags
  typedef struct packed {
    logic accepted;
    logic run_done;
  } gen_flags_t;

endpackage

/* hdl/sspg_core.sv */
module sspg_core import sspg_pkg::*; (
  input  gen_state_t                st,
  input  logic [OP_BITS-1:0]        operation,
  input  logic [COUNT_BITS-1:0]     step_count,
  input  logic                      direction,
  input  logic [CFG_BITS-1:0]       pulse_ticks,
  input  logic [CFG_BITS-1:0]       gap_ticks,
  output gen_state_t                st_next,
  output gen_flags_t                flags
);

  logic [STEP_COUNT_BITS-1:0] start_count;
  logic [TIME_BITS-1:0]       start_high;
  logic [TIME_BITS-1:0]       start_low;
  logic [TIME_BITS-1:0]       wait_dec;
  logic [STEP_COUNT_BITS-1:0] steps_dec;

  // Saturate the requested count and the configured widths
  assign start_count = (step_count > 32'(COUNT_MAX)) ? COUNT_MAX
                                                      : STEP_COUNT_BITS'(step_count);
  assign start_high  = (32'(pulse_ticks) > 32'(TIME_MAX)) ? TIME_MAX
                                                           : TIME_BITS'(pulse_ticks);
  assign start_low   = (32'(gap_ticks) > 32'(TIME_MAX)) ? TIME_MAX
                                                         : TIME_BITS'(gap_ticks);

  assign wait_dec  = (st.wait_left != '0) ? st.wait_left - 1'b1 : '0;
  assign steps_dec = st.steps_left - 1'b1;

  // Advance the generator by one word
  always_comb begin
    st_next        = st;
    flags.accepted = 1'b0;
    flags.run_done = 1'b0;
    case (operation)
      OP_TICK: begin
        if (st.running) begin
          st_next.wait_left = wait_dec;
          if (wait_dec == '0) begin
            if (!st.pulse_high) begin
              st_next.pulse_high = 1'b1;
              st_next.wait_left  = st.active_high_ticks;
            end else begin
              st_next.pulse_high = 1'b0;
              st_next.wait_left  = st.active_low_ticks;
              st_next.steps_left = steps_dec;
              if (steps_dec == '0) begin
                flags.run_done     = 1'b1;
                st_next.running    = 1'b0;
                st_next.enable_reg = 1'b0;
                // Reverse and restart the test run at once
                if (st.test_mode) begin
                  st_next.dir_reg           = ~st.dir_reg;
                  st_next.steps_left        = TEST_STEPS_SAT;
                  st_next.active_high_ticks = TEST_HIGH_SAT;
                  st_next.active_low_ticks  = TEST_LOW_SAT;
                  st_next.wait_left         = '0;
                  st_next.running           = 1'b1;
                  st_next.enable_reg        = 1'b1;
                end
              end
            end
          end
        end
      end
      OP_START: begin
        if (!st.running && start_count != '0) begin
          flags.accepted            = 1'b1;
          st_next.steps_left        = start_count;
          st_next.active_high_ticks = start_high;
          st_next.active_low_ticks  = start_low;
          st_next.wait_left         = '0;
          st_next.pulse_high        = 1'b0;
          st_next.running           = 1'b1;
          st_next.enable_reg        = 1'b1;
        end
      end
      OP_STOP: begin
        st_next.running    = 1'b0;
        st_next.pulse_high = 1'b0;
        st_next.steps_left = '0;
        st_next.wait_left  = '0;
        st_next.test_mode  = 1'b0;
        st_next.enable_reg = 1'b0;
      end
      OP_START_TEST: begin
        st_next.test_mode = 1'b1;
        st_next.dir_reg   = 1'b0;
        if (!st.running && TEST_STEPS_SAT != '0) begin
          flags.accepted            = 1'b1;
          st_next.steps_left        = TEST_STEPS_SAT;
          st_next.active_high_ticks = TEST_HIGH_SAT;
          st_next.active_low_ticks  = TEST_LOW_SAT;
          st_next.wait_left         = '0;
          st_next.pulse_high        = 1'b0;
          st_next.running           = 1'b1;
          st_next.enable_reg        = 1'b1;
        end
      end
      OP_SET_DIR: begin
        st_next.dir_reg = direction;
      end
      default: begin
        st_next = st;
      end
    endcase
  end

endmodule

/* hdl/stepper_step_pulse_generator.sv */
// Channel   Handshake              Payload
// input     in_valid / in_ready    operation, step_count, direction
// result    out_valid / out_ready  step_level, direction_level, driver_enabled,
//                                  busy_res, accepted, run_done
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each input word updates the generator state in the cycle it is accepted and
// its result appears in the output register on the next cycle: one word per
// clock unless out_ready stalls it. The output register frees on the cycle it
// is taken, so input is ready whenever the result slot is empty or being drained.
// rst (synchronous) restores the state and both widths; cfg_ready is always high.
module stepper_step_pulse_generator import sspg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_BITS-1:0]    operation,
  input  logic [COUNT_BITS-1:0] step_count,
  input  logic                  direction,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  step_level,
  output logic                  direction_level,
  output logic                  driver_enabled,
  output logic                  busy_res,
  output logic                  accepted,
  output logic                  run_done,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data
);

  gen_state_t          st;
  gen_state_t          st_next;
  gen_flags_t          flags;
  logic [CFG_BITS-1:0] pulse_ticks;
  logic [CFG_BITS-1:0] gap_ticks;
  logic                in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  sspg_core u_core (
    .st          (st),
    .operation   (operation),
    .step_count  (step_count),
    .direction   (direction),
    .pulse_ticks (pulse_ticks),
    .gap_ticks   (gap_ticks),
    .st_next     (st_next),
    .flags       (flags)
  );

  // Hold the configured widths
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks <= PULSE_TICKS_RESET;
      gap_ticks   <= GAP_TICKS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PULSE_TICKS) begin
        pulse_ticks <= cfg_data;
      end else if (cfg_index == REG_GAP_TICKS) begin
        gap_ticks <= cfg_data;
      end
    end
  end

  // Advance the state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      st.running           <= 1'b0;
      st.pulse_high        <= 1'b0;
      st.steps_left        <= '0;
      st.wait_left         <= '0;
      st.active_high_ticks <= TIME_BITS'(PULSE_TICKS_RESET);
      st.active_low_ticks  <= TIME_BITS'(GAP_TICKS_RESET);
      st.dir_reg           <= 1'b0;
      st.test_mode         <= 1'b0;
      st.enable_reg        <= 1'b0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      step_level      <= st_next.pulse_high;
      direction_level <= st_next.dir_reg;
      driver_enabled  <= st_next.enable_reg;
      busy_res        <= st_next.running;
      accepted        <= flags.accepted;
      run_done        <= flags.run_done;
    end
  end

endmodule

/* test/step_pulse_checker.sv */
module step_pulse_checker import sspg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [OP_BITS-1:0]    operation,
  input  logic [COUNT_BITS-1:0] step_count,
  input  logic                  direction,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  step_level,
  input  logic                  direction_level,
  input  logic                  driver_enabled,
  input  logic                  busy_res,
  input  logic                  accepted,
  input  logic                  run_done,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  output int                    mismatches,
  output int                    pending,
  output int                    runs_ended
);
  timeunit 1ns;
  timeprecision 1ps;

  // One expected result word
  typedef struct packed {
    logic step;
    logic dir;
    logic enabled;
    logic busy;
    logic taken;
    logic done;
  } pulse_word_t;

  gen_state_t            gen;
  logic [CFG_BITS-1:0]   high_width;
  logic [CFG_BITS-1:0]   low_width;
  pulse_word_t           pulse_words[$];

  initial begin
    mismatches = 0;
    pending    = 0;
    runs_ended = 0;
  end

  // Arm a run of steps unless one is in progress or the count is zero
  function automatic logic launch_run(logic [STEP_COUNT_BITS-1:0] n,
                                      logic [TIME_BITS-1:0] hi,
                                      logic [TIME_BITS-1:0] lo);
    if (gen.running || n == '0) return 1'b0;
    gen.steps_left        = n;
    gen.active_high_ticks = hi;
    gen.active_low_ticks  = lo;
    gen.wait_left         = '0;
    gen.pulse_high        = 1'b0;
    gen.running           = 1'b1;
    gen.enable_reg        = 1'b1;
    return 1'b1;
  endfunction

  // Advance the generator by one input word and form its result
  function automatic pulse_word_t advance_generator(logic [OP_BITS-1:0] op,
                                                    logic [COUNT_BITS-1:0] cnt,
                                                    logic d);
    pulse_word_t w;
    w.taken = 1'b0;
    w.done  = 1'b0;
    case (op)
      OP_TICK: begin
        if (gen.running) begin
          if (gen.wait_left != '0) gen.wait_left = gen.wait_left - 1'b1;
          if (gen.wait_left == '0) begin
            if (!gen.pulse_high) begin
              gen.pulse_high = 1'b1;
              gen.wait_left  = gen.active_high_ticks;
            end else begin
              gen.pulse_high = 1'b0;
              gen.wait_left  = gen.active_low_ticks;
              gen.steps_left = gen.steps_left - 1'b1;
              if (gen.steps_left == '0) begin
                w.done         = 1'b1;
                gen.running    = 1'b0;
                gen.enable_reg = 1'b0;
                // Continuous test: reverse and restart at once
                if (gen.test_mode) begin
                  gen.dir_reg = ~gen.dir_reg;
                  void'(launch_run(TEST_STEPS_SAT, TEST_HIGH_SAT, TEST_LOW_SAT));
                end
              end
            end
          end
        end
      end
      OP_START: begin
        w.taken = launch_run(STEP_COUNT_BITS'(cnt), high_width, low_width);
      end
      OP_STOP: begin
        gen.running    = 1'b0;
        gen.pulse_high = 1'b0;
        gen.steps_left = '0;
        gen.wait_left  = '0;
        gen.test_mode  = 1'b0;
        gen.enable_reg = 1'b0;
      end
      OP_START_TEST: begin
        gen.test_mode = 1'b1;
        gen.dir_reg   = 1'b0;
        w.taken = launch_run(TEST_STEPS_SAT, TEST_HIGH_SAT, TEST_LOW_SAT);
      end
      OP_SET_DIR: begin
        gen.dir_reg = d;
      end
      default: ;
    endcase
    w.step    = gen.pulse_high;
    w.dir     = gen.dir_reg;
    w.enabled = gen.enable_reg;
    w.busy    = gen.running;
    return w;
  endfunction

  task automatic check_field(input string field, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      mismatches++;
    end
  endtask

  // Track config, queue predictions, compare results in order
  always @(posedge clk) begin
    pulse_word_t want;
    if (rst) begin
      gen.running           = 1'b0;
      gen.pulse_high        = 1'b0;
      gen.steps_left        = '0;
      gen.wait_left         = '0;
      gen.active_high_ticks = TIME_BITS'(100);
      gen.active_low_ticks  = TIME_BITS'(800);
      gen.dir_reg           = 1'b0;
      gen.test_mode         = 1'b0;
      gen.enable_reg        = 1'b0;
      high_width            = PULSE_TICKS_RESET;
      low_width             = GAP_TICKS_RESET;
      pulse_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PULSE_TICKS: high_width = cfg_data;
          REG_GAP_TICKS:   low_width  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = advance_generator(operation, step_count, direction);
        if (want.done) runs_ended++;
        pulse_words.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pulse_words.size() == 0) begin
          $error("result word arrived with no prediction waiting");
          mismatches++;
        end else begin
          want = pulse_words.pop_front();
          check_field("step_level", want.step, step_level);
          check_field("direction_level", want.dir, direction_level);
          check_field("driver_enabled", want.enabled, driver_enabled);
          check_field("busy_res", want.busy, busy_res);
          check_field("accepted", want.taken, accepted);
          check_field("run_done", want.done, run_done);
        end
      end
    end
    pending <= pulse_words.size();
  end

endmodule

/* test/tb.sv */
module tb import sspg_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [INDEX_BITS-1:0] REG_SPARE_B = 2'd3;
  localparam logic [OP_BITS-1:0]    OP_RESERVED_FIRST = 3'd5;
  localparam logic [OP_BITS-1:0]    OP_RESERVED_MID   = 3'd6;
  localparam logic [OP_BITS-1:0]    OP_RESERVED_LAST  = 3'd7;
  localparam int                    WORDS_PER_STAGE   = 170;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [OP_BITS-1:0]    operation;
  logic [COUNT_BITS-1:0] step_count;
  logic                  direction;
  logic                  out_valid;
  logic                  out_ready;
  logic                  step_level;
  logic                  direction_level;
  logic                  driver_enabled;
  logic                  busy_res;
  logic                  accepted;
  logic                  run_done;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]   cfg_data;

  int mismatches;
  int pending;
  int runs_ended;
  int send_idle;
  int recv_idle;
  int words_sent;
  int cfg_writes;

  stepper_step_pulse_generator dut (.*);

  step_pulse_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[stepper_step_pulse_generator] ERROR");
    $finish;
  end

  // Receiver: stall the result channel at the current rate
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= (rst == 1'b0) && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Present one word, with random idle cycles ahead of it
  task automatic push_word(input logic [OP_BITS-1:0] op,
                           input logic [COUNT_BITS-1:0] cnt, input logic d);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    step_count <= cnt;
    direction  <= d;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic write_reg(input logic [INDEX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
  endtask

  // Drain the block, then load both widths and poke a spare index
  task automatic apply_widths(input logic [CFG_BITS-1:0] hi, input logic [CFG_BITS-1:0] lo);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    write_reg(REG_PULSE_TICKS, hi);
    write_reg(REG_GAP_TICKS, lo);
    write_reg($urandom_range(0, 1) ? REG_SPARE_B : REG_SPARE_A, CFG_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly ticks and short runs, with stops, reversals and junk mixed in
  task automatic random_word();
    int r;
    int c;
    logic [COUNT_BITS-1:0] cnt;
    r = $urandom_range(0, 99);
    c = $urandom_range(0, 9);
    if (c < 7) cnt = $urandom_range(1, 4);
    else if (c == 7) cnt = '0;
    else if (c == 8) cnt = '1;
    else cnt = $urandom;
    if (r < 72) push_word(OP_TICK, $urandom, 1'($urandom_range(0, 1)));
    else if (r < 80) push_word(OP_START, cnt, 1'($urandom_range(0, 1)));
    else if (r < 83) push_word(OP_STOP, $urandom, 1'($urandom_range(0, 1)));
    else if (r < 88) push_word(OP_SET_DIR, $urandom, 1'($urandom_range(0, 1)));
    else if (r < 90) push_word(OP_START_TEST, $urandom, 1'($urandom_range(0, 1)));
    else if (r < 92)
      push_word(OP_BITS'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST)), $urandom,
                1'($urandom_range(0, 1)));
    else push_word(OP_TICK, $urandom, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int stage;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    operation  <= OP_TICK;
    step_count <= '0;
    direction  <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_PULSE_TICKS;
    cfg_data   <= '0;
    send_idle  = 0;
    recv_idle  = 0;
    words_sent = 0;
    cfg_writes = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle tick, junk codes, direction, rejects, test takeover
    apply_widths(CFG_BITS'(1), CFG_BITS'(0));
    push_word(OP_TICK, '0, 1'b0);
    push_word(OP_RESERVED_FIRST, '1, 1'b1);
    push_word(OP_RESERVED_MID, '0, 1'b0);
    push_word(OP_RESERVED_LAST, '1, 1'b1);
    push_word(OP_SET_DIR, '0, 1'b1);
    push_word(OP_SET_DIR, '1, 1'b0);
    push_word(OP_START, '0, 1'b0);
    push_word(OP_START, COUNT_BITS'(2), 1'b0);
    push_word(OP_START, COUNT_BITS'(5), 1'b1);
    repeat (3) push_word(OP_TICK, '0, 1'b0);
    // Test start while busy: the short run ends and the test takes over
    push_word(OP_START_TEST, '0, 1'b0);
    repeat (8) push_word(OP_TICK, '1, 1'b1);
    push_word(OP_STOP, '0, 1'b0);
    push_word(OP_START, '1, 1'b0);
    push_word(OP_TICK, '0, 1'b0);
    push_word(OP_STOP, '1, 1'b1);
    push_word(OP_START_TEST, '0, 1'b0);
    push_word(OP_TICK, '0, 1'b0);
    push_word(OP_STOP, '0, 1'b0);

    // Random: three handshake mixes, four width settings each
    for (stage = 0; stage < 12; stage++) begin
      case (stage)
        0:  apply_widths(CFG_BITS'(0), CFG_BITS'(0));
        1:  apply_widths(CFG_BITS'(1), CFG_BITS'(2));
        2:  apply_widths('1, CFG_BITS'(0));
        3:  apply_widths(CFG_BITS'(3), CFG_BITS'(1));
        4:  apply_widths(CFG_BITS'(0), '1);
        5:  apply_widths(CFG_BITS'($urandom_range(0, 5)), CFG_BITS'($urandom_range(0, 5)));
        6:  apply_widths(CFG_BITS'(2), CFG_BITS'(0));
        7:  apply_widths('1, '1);
        8:  apply_widths(CFG_BITS'($urandom_range(0, 3)), CFG_BITS'($urandom_range(0, 3)));
        9:  apply_widths(CFG_BITS'(0), CFG_BITS'(1));
        10: apply_widths(PULSE_TICKS_RESET, GAP_TICKS_RESET);
        default: apply_widths(CFG_BITS'($urandom_range(0, 7)), CFG_BITS'($urandom_range(0, 7)));
      endcase
      if (stage < 4) begin
        send_idle = 35;
        recv_idle = 58;
      end else if (stage < 8) begin
        send_idle = 58;
        recv_idle = 35;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      repeat (WORDS_PER_STAGE) random_word();
    end

    // Drain and settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d words and %0d register writes over 13 width settings,",
             words_sent, cfg_writes);
    $display("three handshake mixes and %0d completed runs.", runs_ended);
    if (mismatches == 0) begin
      $display("[stepper_step_pulse_generator] OK");
    end else begin
      $display("[stepper_step_pulse_generator] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/sspg_pkg.sv
hdl/sspg_core.sv
hdl/stepper_step_pulse_generator.sv
test/step_pulse_checker.sv
test/tb.sv
